/* hdl/mbie_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbie_pkg: shared definitions of the branch and immediate execute block
// Opcode codes, status codes, address constants and the result record.
// ----------------------------------------------------------------------------
package mbie_pkg;

  localparam int unsigned OP_W   = 6;
  localparam int unsigned DATA_W = 64;
  localparam int unsigned REG_W  = 5;
  localparam int unsigned IMM_W  = 16;
  localparam int unsigned IDX_W  = 26;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned ST_W   = 2;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_OTHER   = 2'd1;
  localparam logic [ST_W-1:0] ST_UNKNOWN = 2'd2;

  localparam logic [REG_W-1:0]  LINK_REG    = 5'd31;
  localparam logic [ADDR_W-1:0] REGION_MASK = 32'hf000_0000;
  localparam logic [ADDR_W-1:0] INSTR_BYTES = 32'd4;
  localparam logic [ADDR_W-1:0] SLOT_BYTES  = 32'd8;

  // primary opcodes
  localparam logic [OP_W-1:0] OP_J      = 6'd2;
  localparam logic [OP_W-1:0] OP_JAL    = 6'd3;
  localparam logic [OP_W-1:0] OP_BEQ    = 6'd4;
  localparam logic [OP_W-1:0] OP_BNE    = 6'd5;
  localparam logic [OP_W-1:0] OP_BLEZ   = 6'd6;
  localparam logic [OP_W-1:0] OP_BGTZ   = 6'd7;
  localparam logic [OP_W-1:0] OP_ADDI   = 6'd8;
  localparam logic [OP_W-1:0] OP_ADDIU  = 6'd9;
  localparam logic [OP_W-1:0] OP_SLTI   = 6'd10;
  localparam logic [OP_W-1:0] OP_SLTIU  = 6'd11;
  localparam logic [OP_W-1:0] OP_ANDI   = 6'd12;
  localparam logic [OP_W-1:0] OP_ORI    = 6'd13;
  localparam logic [OP_W-1:0] OP_XORI   = 6'd14;
  localparam logic [OP_W-1:0] OP_LUI    = 6'd15;
  localparam logic [OP_W-1:0] OP_RSV18  = 6'd18;
  localparam logic [OP_W-1:0] OP_RSV19  = 6'd19;
  localparam logic [OP_W-1:0] OP_BEQL   = 6'd20;
  localparam logic [OP_W-1:0] OP_BNEL   = 6'd21;
  localparam logic [OP_W-1:0] OP_BLEZL  = 6'd22;
  localparam logic [OP_W-1:0] OP_BGTZL  = 6'd23;
  localparam logic [OP_W-1:0] OP_DADDI  = 6'd24;
  localparam logic [OP_W-1:0] OP_DADDIU = 6'd25;
  localparam logic [OP_W-1:0] OP_RSV28  = 6'd28;
  localparam logic [OP_W-1:0] OP_RSV29  = 6'd29;
  localparam logic [OP_W-1:0] OP_RSV30  = 6'd30;
  localparam logic [OP_W-1:0] OP_RSV31  = 6'd31;
  localparam logic [OP_W-1:0] OP_RSV50  = 6'd50;
  localparam logic [OP_W-1:0] OP_RSV51  = 6'd51;
  localparam logic [OP_W-1:0] OP_RSV58  = 6'd58;
  localparam logic [OP_W-1:0] OP_RSV59  = 6'd59;

  typedef struct packed {
    logic [OP_W-1:0]   kind;
    logic [DATA_W-1:0] rs_value;
    logic [DATA_W-1:0] rt_value;
    logic [REG_W-1:0]  rt_index;
    logic [IMM_W-1:0]  immediate;
    logic [IDX_W-1:0]  jump_index;
    logic [ADDR_W-1:0] instr_address;
  } beat_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic              write_enable;
    logic [REG_W-1:0]  write_register;
    logic [DATA_W-1:0] write_value;
    logic              branch_taken;
    logic              skip_delay_slot;
    logic [ADDR_W-1:0] next_address;
  } result_t;

endpackage

/* hdl/mbie_exec.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbie_exec: decode and execute core
// Decodes the primary opcode and forms write-back, next address and flags.
// ----------------------------------------------------------------------------
module mbie_exec (
  input  mbie_pkg::beat_t   beat,
  output mbie_pkg::result_t result
);

  logic [mbie_pkg::DATA_W-1:0] imm_sext;
  logic [mbie_pkg::DATA_W-1:0] imm_zext;
  logic [mbie_pkg::DATA_W-1:0] sum;
  logic [mbie_pkg::ADDR_W-1:0] seq;
  logic [mbie_pkg::ADDR_W-1:0] past_slot;
  logic [mbie_pkg::ADDR_W-1:0] btarget;
  logic [mbie_pkg::ADDR_W-1:0] jtarget;
  logic                        rs_zero;
  logic                        rs_neg;
  logic                        is_branch;
  logic                        cond;

  assign imm_sext  = {{(mbie_pkg::DATA_W-mbie_pkg::IMM_W){beat.immediate[mbie_pkg::IMM_W-1]}},
                      beat.immediate};
  assign imm_zext  = {{(mbie_pkg::DATA_W-mbie_pkg::IMM_W){1'b0}}, beat.immediate};
  assign sum       = beat.rs_value + imm_sext;
  assign seq       = beat.instr_address + mbie_pkg::INSTR_BYTES;
  assign past_slot = beat.instr_address + mbie_pkg::SLOT_BYTES;
  assign btarget   = seq + {imm_sext[mbie_pkg::ADDR_W-3:0], 2'b00};
  assign jtarget   = (seq & mbie_pkg::REGION_MASK)
                   | {{(mbie_pkg::ADDR_W-mbie_pkg::IDX_W-2){1'b0}}, beat.jump_index, 2'b00};
  assign rs_zero   = (beat.rs_value == '0);
  assign rs_neg    = beat.rs_value[mbie_pkg::DATA_W-1];

  always_comb begin
    result                = '0;
    result.status         = mbie_pkg::ST_DONE;
    result.next_address   = seq;
    is_branch             = 1'b0;
    cond                  = 1'b0;
    unique case (beat.kind) inside
      mbie_pkg::OP_J: begin
        result.branch_taken = 1'b1;
        result.next_address = jtarget;
      end
      mbie_pkg::OP_JAL: begin
        result.branch_taken   = 1'b1;
        result.next_address   = jtarget;
        result.write_enable   = 1'b1;
        result.write_register = mbie_pkg::LINK_REG;
        result.write_value    = {{(mbie_pkg::DATA_W-mbie_pkg::ADDR_W){past_slot[mbie_pkg::ADDR_W-1]}},
                                 past_slot};
      end
      mbie_pkg::OP_BEQ, mbie_pkg::OP_BEQL: begin
        is_branch = 1'b1;
        cond      = (beat.rs_value == beat.rt_value);
      end
      mbie_pkg::OP_BNE, mbie_pkg::OP_BNEL: begin
        is_branch = 1'b1;
        cond      = (beat.rs_value != beat.rt_value);
      end
      mbie_pkg::OP_BLEZ, mbie_pkg::OP_BLEZL: begin
        is_branch = 1'b1;
        cond      = rs_neg | rs_zero;
      end
      mbie_pkg::OP_BGTZ, mbie_pkg::OP_BGTZL: begin
        is_branch = 1'b1;
        cond      = !rs_neg && !rs_zero;
      end
      mbie_pkg::OP_ADDI, mbie_pkg::OP_ADDIU: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = {{(mbie_pkg::DATA_W-mbie_pkg::ADDR_W){sum[mbie_pkg::ADDR_W-1]}},
                                 sum[mbie_pkg::ADDR_W-1:0]};
      end
      mbie_pkg::OP_SLTI: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = {{(mbie_pkg::DATA_W-1){1'b0}},
                                 ($signed(beat.rs_value) < $signed(imm_sext))};
      end
      mbie_pkg::OP_SLTIU: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = {{(mbie_pkg::DATA_W-1){1'b0}}, (beat.rs_value < imm_sext)};
      end
      mbie_pkg::OP_ANDI: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = beat.rs_value & imm_zext;
      end
      mbie_pkg::OP_ORI: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = beat.rs_value | imm_zext;
      end
      mbie_pkg::OP_XORI: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = beat.rs_value ^ imm_zext;
      end
      mbie_pkg::OP_LUI: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = {{(mbie_pkg::DATA_W-mbie_pkg::ADDR_W){beat.immediate[mbie_pkg::IMM_W-1]}},
                                 beat.immediate, {mbie_pkg::IMM_W{1'b0}}};
      end
      mbie_pkg::OP_DADDI, mbie_pkg::OP_DADDIU: begin
        result.write_enable   = 1'b1;
        result.write_register = beat.rt_index;
        result.write_value    = sum;
      end
      mbie_pkg::OP_RSV18, mbie_pkg::OP_RSV19, mbie_pkg::OP_RSV28, mbie_pkg::OP_RSV29,
      mbie_pkg::OP_RSV30, mbie_pkg::OP_RSV31, mbie_pkg::OP_RSV50, mbie_pkg::OP_RSV51,
      mbie_pkg::OP_RSV58, mbie_pkg::OP_RSV59: begin
        result.status = mbie_pkg::ST_UNKNOWN;
      end
      default: begin
        result.status = mbie_pkg::ST_OTHER;
      end
    endcase

    if (is_branch) begin
      if (cond) begin
        result.branch_taken = 1'b1;
        result.next_address = btarget;
      end else begin
        result.next_address    = past_slot;
        // likely forms sit in the upper opcode group
        result.skip_delay_slot = (beat.kind >= mbie_pkg::OP_BEQL);
      end
    end
  end

endmodule

/* hdl/mips_branch_immediate_execute.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_branch_immediate_execute: branch, jump and immediate-ALU execute
//
//   channel   handshake           payload
//   -------   -----------------   ------------------------------------------
//   command   start / busy        kind, rs_value, rt_value, rt_index,
//                                 immediate, jump_index, instr_address
//   result    done (one cycle)    status, write_enable, write_register,
//                                 write_value, branch_taken,
//                                 skip_delay_slot, next_address
//
// One beat is taken every cycle; busy stays low. Each command is captured in
// the input register, then passes through the decode and adder logic into the
// result register. Synchronous reset clears both valid flags. The receiver
// cannot stall, so nothing is held back.
// ----------------------------------------------------------------------------
module mips_branch_immediate_execute (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [mbie_pkg::OP_W-1:0]   kind,
  input  logic [mbie_pkg::DATA_W-1:0] rs_value,
  input  logic [mbie_pkg::DATA_W-1:0] rt_value,
  input  logic [mbie_pkg::REG_W-1:0]  rt_index,
  input  logic [mbie_pkg::IMM_W-1:0]  immediate,
  input  logic [mbie_pkg::IDX_W-1:0]  jump_index,
  input  logic [mbie_pkg::ADDR_W-1:0] instr_address,
  output logic                        done,
  output logic [mbie_pkg::ST_W-1:0]   status,
  output logic                        write_enable,
  output logic [mbie_pkg::REG_W-1:0]  write_register,
  output logic [mbie_pkg::DATA_W-1:0] write_value,
  output logic                        branch_taken,
  output logic                        skip_delay_slot,
  output logic [mbie_pkg::ADDR_W-1:0] next_address
);

  mbie_pkg::beat_t   beat;
  logic              beat_valid;
  mbie_pkg::result_t result_next;
  mbie_pkg::result_t result;

  assign busy = 1'b0;

  // capture the command beat
  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else begin
      beat_valid <= start && !busy;
    end
    if (start && !busy) begin
      beat.kind          <= kind;
      beat.rs_value      <= rs_value;
      beat.rt_value      <= rt_value;
      beat.rt_index      <= rt_index;
      beat.immediate     <= immediate;
      beat.jump_index    <= jump_index;
      beat.instr_address <= instr_address;
    end
  end

  mbie_exec u_exec (
    .beat   (beat),
    .result (result_next)
  );

  // register the result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= beat_valid;
    end
    if (beat_valid) begin
      result <= result_next;
    end
  end

  assign status          = result.status;
  assign write_enable    = result.write_enable;
  assign write_register  = result.write_register;
  assign write_value     = result.write_value;
  assign branch_taken    = result.branch_taken;
  assign skip_delay_slot = result.skip_delay_slot;
  assign next_address    = result.next_address;

endmodule
